>>> hdl/bib_pkg.sv
// Shared widths, register codes and sideband type for the boid integrator.
package bib_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 27;
	localparam int VEL_W     = 23;
	localparam int ACC_W     = 28;
	localparam int DT_W      = 17;
	localparam int SPD_W     = 23;
	localparam int HALF_W    = 26;
	localparam int VX_W      = 30;            // velocity before clamp
	localparam int L2_W      = 58;            // squared length
	localparam int ROOT_W    = L2_W / 2;      // floor sqrt
	localparam int SREM_W    = ROOT_W + 2;    // sqrt remainder
	localparam int Q_W       = SPD_W;         // scaled component magnitude
	localparam int MAG_W     = ROOT_W;
	localparam int NUM_W     = MAG_W + SPD_W + 1;
	localparam int DREM_W    = ROOT_W;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE  = 8'd3;

	typedef struct packed {
		logic [2:0][POS_W-1:0] pos;
		logic [2:0][VX_W-1:0]  vel;
		logic [DT_W-1:0]       dt;
		logic [SPD_W-1:0]      target;
		logic                  scale;
	} bib_side_t;

endpackage

>>> hdl/bib_isqrt.sv
// Pipelined floor square root, one root bit per stage, sideband carried along.
module bib_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [bib_pkg::L2_W-1:0]    in_x,
	input  bib_pkg::bib_side_t          in_side,
	output logic                        out_valid,
	output logic [bib_pkg::ROOT_W-1:0]  out_root,
	output bib_pkg::bib_side_t          out_side
);

	localparam int NS = bib_pkg::ROOT_W;

	logic                         vld   [NS+1];
	logic [bib_pkg::L2_W-1:0]     xs    [NS+1];
	logic [bib_pkg::SREM_W-1:0]   rem   [NS+1];
	logic [bib_pkg::ROOT_W-1:0]   root  [NS+1];
	bib_pkg::bib_side_t           side  [NS+1];

	assign vld[0]  = in_valid;
	assign xs[0]   = in_x;
	assign rem[0]  = '0;
	assign root[0] = '0;
	assign side[0] = in_side;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [bib_pkg::SREM_W+1:0] pre;
		logic [bib_pkg::SREM_W+1:0] trial;
		logic [bib_pkg::SREM_W+1:0] diff;
		logic                       ge;

		assign pre   = {rem[k], xs[k][bib_pkg::L2_W-1 -: 2]};
		assign trial = {2'b00, root[k], 2'b01};
		assign ge    = pre >= trial;
		assign diff  = pre - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				xs[k+1]   <= {xs[k][bib_pkg::L2_W-3:0], 2'b00};
				rem[k+1]  <= ge ? diff[bib_pkg::SREM_W-1:0] : pre[bib_pkg::SREM_W-1:0];
				root[k+1] <= {root[k][bib_pkg::ROOT_W-2:0], ge};
				side[k+1] <= side[k];
			end
		end
	end

	assign out_valid = vld[NS];
	assign out_root  = root[NS];
	assign out_side  = side[NS];

endmodule

>>> hdl/bib_div.sv
// Pipelined restoring divider, three lanes over a shared divisor, one quotient bit per stage.
module bib_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [2:0][bib_pkg::NUM_W-1:0]    in_num,
	input  logic [bib_pkg::ROOT_W-1:0]        in_den,
	input  bib_pkg::bib_side_t                in_side,
	output logic                              out_valid,
	output logic [2:0][bib_pkg::Q_W-1:0]      out_quo,
	output bib_pkg::bib_side_t                out_side
);

	localparam int NS = bib_pkg::Q_W;

	logic                                 vld  [NS+1];
	logic [bib_pkg::ROOT_W-1:0]           den  [NS+1];
	logic [2:0][bib_pkg::DREM_W-1:0]      rem  [NS+1];
	logic [2:0][bib_pkg::Q_W-1:0]         nl   [NS+1];
	logic [2:0][bib_pkg::Q_W-1:0]         quo  [NS+1];
	bib_pkg::bib_side_t                   side [NS+1];

	assign vld[0]  = in_valid;
	assign den[0]  = in_den;
	assign quo[0]  = '0;
	assign side[0] = in_side;

	for (genvar l = 0; l < 3; l++) begin : g_init
		assign rem[0][l] = in_num[l][bib_pkg::NUM_W-2 -: bib_pkg::DREM_W];
		assign nl[0][l]  = in_num[l][bib_pkg::Q_W-1:0];
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [2:0][bib_pkg::DREM_W:0]   pre;
		logic [2:0][bib_pkg::DREM_W:0]   diff;
		logic [2:0]                      ge;

		for (genvar l = 0; l < 3; l++) begin : g_lane
			assign pre[l]  = {rem[k][l], nl[k][l][bib_pkg::Q_W-1]};
			assign ge[l]   = pre[l] >= {1'b0, den[k]};
			assign diff[l] = pre[l] - {1'b0, den[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den[k+1]  <= den[k];
				side[k+1] <= side[k];
				for (int l = 0; l < 3; l++) begin
					rem[k+1][l] <= ge[l] ? diff[l][bib_pkg::DREM_W-1:0]
					                     : pre[l][bib_pkg::DREM_W-1:0];
					nl[k+1][l]  <= {nl[k][l][bib_pkg::Q_W-2:0], 1'b0};
					quo[k+1][l] <= {quo[k][l][bib_pkg::Q_W-2:0], ge[l]};
				end
			end
		end
	end

	assign out_valid = vld[NS];
	assign out_quo   = quo[NS];
	assign out_side  = side[NS];

endmodule

>>> hdl/boid_integrate_and_bound.sv
// Boid Euler step: velocity update, speed clamp, position update, world boundary.
// Pipeline: 5 front stages, 29 sqrt stages, 2 scale stages, 23 divide stages,
// 4 position stages, then the output register that drives m_tvalid.
// Throughput: one item per cycle; the whole pipeline holds only while the
// output skid register is full.
// Reset: arst_n clears all valid bits and loads the register reset values.
module boid_integrate_and_bound (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, time_step
	input  logic [255:0]                      s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
	output logic [151:0]                      m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bib_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bib_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int F = bib_pkg::FRAC_BITS;
	localparam int PW = bib_pkg::ACC_W + bib_pkg::DT_W + 1;   // acc*dt
	localparam int VPW = bib_pkg::VEL_W + bib_pkg::DT_W + 1;  // vel*dt

	function automatic logic [bib_pkg::VEL_W-1:0] sat_vel(input logic signed [bib_pkg::VX_W-1:0] x);
		if (x > $signed(bib_pkg::VX_W'(4194303)))
			return 23'h3FFFFF;
		else if (x < -$signed(bib_pkg::VX_W'(4194304)))
			return 23'h400000;
		else
			return x[bib_pkg::VEL_W-1:0];
	endfunction

	function automatic logic [bib_pkg::POS_W-1:0] sat_pos(input logic signed [bib_pkg::VX_W-1:0] x);
		if (x > $signed(bib_pkg::VX_W'(67108863)))
			return 27'h3FFFFFF;
		else if (x < -$signed(bib_pkg::VX_W'(67108864)))
			return 27'h4000000;
		else
			return x[bib_pkg::POS_W-1:0];
	endfunction

	// configuration
	logic [bib_pkg::SPD_W-1:0]    min_speed_q, max_speed_q;
	logic [bib_pkg::HALF_W-1:0]   half_q;
	logic                         wrap_q;
	logic [2*bib_pkg::SPD_W-1:0]  minsq_q, maxsq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= 23'd327680;
			max_speed_q <= 23'd983040;
			half_q      <= 26'd13107200;
			wrap_q      <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				bib_pkg::REG_MIN_SPEED: min_speed_q <= cfg_data[bib_pkg::SPD_W-1:0];
				bib_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data[bib_pkg::SPD_W-1:0];
				bib_pkg::REG_HALF_SIZE: half_q      <= cfg_data[bib_pkg::HALF_W-1:0];
				bib_pkg::REG_WRAP_MODE: wrap_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		minsq_q <= min_speed_q * min_speed_q;
		maxsq_q <= max_speed_q * max_speed_q;
	end

	logic adv;

	// input unpack
	logic [2:0][bib_pkg::POS_W-1:0] pos_in;
	logic [2:0][bib_pkg::VEL_W-1:0] vel_in;
	logic [2:0][bib_pkg::ACC_W-1:0] acc_in;
	logic [bib_pkg::DT_W-1:0]       dt_in;

	assign pos_in[0] = s_tdata[26:0];
	assign pos_in[1] = s_tdata[53:27];
	assign pos_in[2] = s_tdata[80:54];
	assign vel_in[0] = s_tdata[103:81];
	assign vel_in[1] = s_tdata[126:104];
	assign vel_in[2] = s_tdata[149:127];
	assign acc_in[0] = s_tdata[177:150];
	assign acc_in[1] = s_tdata[205:178];
	assign acc_in[2] = s_tdata[233:206];
	assign dt_in     = s_tdata[250:234];

	// front stages
	logic                            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][bib_pkg::POS_W-1:0]  pos_s1, pos_s2, pos_s3, pos_s4;
	logic [2:0][bib_pkg::VEL_W-1:0]  vel_s1;
	logic [2:0][PW-1:0]              prod_s1;
	logic [2:0][bib_pkg::VX_W-1:0]   vx_s2, vx_s3, vx_s4;
	logic [2:0][bib_pkg::L2_W-1:0]   sq_s3;
	logic [bib_pkg::L2_W-1:0]        l2_s4, l2_s5;
	logic [bib_pkg::DT_W-1:0]        dt_s1, dt_s2, dt_s3, dt_s4;
	bib_pkg::bib_side_t              side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic [2:0][PW-1:0]               rnd_s2;
	logic [2:0][bib_pkg::VX_W-1:0]    mdt_s2;
	logic [2:0][2*bib_pkg::VX_W-1:0]  sqf_s3;
	logic                             lo_s5, hi_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_s2[i] = prod_s1[i] + PW'(1 << (F - 1));
			mdt_s2[i] = rnd_s2[i][F +: bib_pkg::VX_W];
			sqf_s3[i] = $signed(vx_s2[i]) * $signed(vx_s2[i]);
		end
		lo_s5 = l2_s4 < bib_pkg::L2_W'(minsq_q);
		hi_s5 = l2_s4 > bib_pkg::L2_W'(maxsq_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= pos_in;
			vel_s1 <= vel_in;
			dt_s1  <= dt_in;
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= PW'($signed(acc_in[i]) * $signed({1'b0, dt_in}));

			pos_s2 <= pos_s1;
			dt_s2  <= dt_s1;
			for (int i = 0; i < 3; i++)
				vx_s2[i] <= bib_pkg::VX_W'($signed(vel_s1[i])) + mdt_s2[i];

			pos_s3 <= pos_s2;
			dt_s3  <= dt_s2;
			vx_s3  <= vx_s2;
			for (int i = 0; i < 3; i++)
				sq_s3[i] <= sqf_s3[i][bib_pkg::L2_W-1:0];

			pos_s4 <= pos_s3;
			dt_s4  <= dt_s3;
			vx_s4  <= vx_s3;
			l2_s4  <= sq_s3[0] + sq_s3[1] + sq_s3[2];

			l2_s5          <= l2_s4;
			side_s5.pos    <= pos_s4;
			side_s5.vel    <= vx_s4;
			side_s5.dt     <= dt_s4;
			side_s5.target <= lo_s5 ? min_speed_q : max_speed_q;
			side_s5.scale  <= (l2_s4 != '0) && (lo_s5 || hi_s5);
		end
	end

	// square root
	logic                         sq_v;
	logic [bib_pkg::ROOT_W-1:0]   sq_root;
	bib_pkg::bib_side_t           sq_side;

	bib_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.in_x      (l2_s5),
		.in_side   (side_s5),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// numerators |v|*target + len/2
	logic                               v_m1, v_m2;
	logic [2:0][bib_pkg::NUM_W-2:0]     prod_m1;
	logic [bib_pkg::ROOT_W-1:0]         len_m1, len_m2;
	bib_pkg::bib_side_t                 side_m1, side_m2;
	logic [2:0][bib_pkg::NUM_W-1:0]     num_m2;
	logic [2:0][bib_pkg::VX_W-1:0]      absv;

	always_comb begin
		for (int i = 0; i < 3; i++)
			absv[i] = sq_side.vel[i][bib_pkg::VX_W-1] ? -sq_side.vel[i] : sq_side.vel[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (adv) begin
			v_m1 <= sq_v;
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				prod_m1[i] <= absv[i][bib_pkg::MAG_W-1:0] * sq_side.target;
			len_m1  <= sq_root;
			side_m1 <= sq_side;
			for (int i = 0; i < 3; i++)
				num_m2[i] <= {1'b0, prod_m1[i]} + bib_pkg::NUM_W'(len_m1 >> 1);
			len_m2  <= len_m1;
			side_m2 <= side_m1;
		end
	end

	// divide
	logic                             dv_v;
	logic [2:0][bib_pkg::Q_W-1:0]     dv_q;
	bib_pkg::bib_side_t               dv_side;

	bib_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_m2),
		.in_num    (num_m2),
		.in_den    (len_m2),
		.in_side   (side_m2),
		.out_valid (dv_v),
		.out_quo   (dv_q),
		.out_side  (dv_side)
	);

	// velocity select, position update, boundary
	logic                               v_p1, v_p2, v_p3, v_p4;
	logic [2:0][bib_pkg::VEL_W-1:0]     vs_p1, vs_p2, vs_p3;
	logic [2:0][bib_pkg::POS_W-1:0]     pos_p1, pos_p2;
	logic [bib_pkg::DT_W-1:0]           dt_p1;
	logic [2:0][VPW-1:0]                pm_p2;
	logic [2:0][bib_pkg::VX_W-1:0]      p_p3;
	logic [2:0][bib_pkg::POS_W-1:0]     npos_p4;
	logic [2:0][bib_pkg::VEL_W-1:0]     nvel_p4;
	logic                               wrap_p;

	logic [2:0][bib_pkg::VX_W-1:0]      sel_v, qv;
	logic [2:0][VPW-1:0]                rnd_p3;
	logic signed [bib_pkg::VX_W-1:0]    lim, lim2;
	logic [2:0][bib_pkg::VX_W-1:0]      pb, vb;

	assign wrap_p = wrap_q;
	assign lim    = $signed(bib_pkg::VX_W'(half_q));
	assign lim2   = $signed(bib_pkg::VX_W'({half_q, 1'b0}));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv[i] = bib_pkg::VX_W'(dv_q[i]);
			if (!dv_side.scale)
				sel_v[i] = dv_side.vel[i];
			else if (dv_side.vel[i][bib_pkg::VX_W-1])
				sel_v[i] = -qv[i];
			else
				sel_v[i] = qv[i];
			rnd_p3[i] = pm_p2[i] + VPW'(1 << (F - 1));
			pb[i] = p_p3[i];
			vb[i] = bib_pkg::VX_W'($signed(vs_p3[i]));
			if ($signed(p_p3[i]) > lim) begin
				if (wrap_p) begin
					pb[i] = $signed(p_p3[i]) - lim2;
				end else begin
					pb[i] = lim2 - $signed(p_p3[i]);
					vb[i] = -bib_pkg::VX_W'($signed(vs_p3[i]));
				end
			end else if ($signed(p_p3[i]) < -lim) begin
				if (wrap_p) begin
					pb[i] = $signed(p_p3[i]) + lim2;
				end else begin
					pb[i] = -lim2 - $signed(p_p3[i]);
					vb[i] = -bib_pkg::VX_W'($signed(vs_p3[i]));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
		end else if (adv) begin
			v_p1 <= dv_v;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				vs_p1[i] <= sat_vel(sel_v[i]);
			pos_p1 <= dv_side.pos;
			dt_p1  <= dv_side.dt;

			for (int i = 0; i < 3; i++)
				pm_p2[i] <= VPW'($signed(vs_p1[i]) * $signed({1'b0, dt_p1}));
			vs_p2  <= vs_p1;
			pos_p2 <= pos_p1;

			for (int i = 0; i < 3; i++)
				p_p3[i] <= bib_pkg::VX_W'($signed(pos_p2[i]))
				         + bib_pkg::VX_W'($signed(rnd_p3[i][VPW-1:F]));
			vs_p3  <= vs_p2;

			for (int i = 0; i < 3; i++) begin
				npos_p4[i] <= sat_pos(pb[i]);
				nvel_p4[i] <= sat_vel(vb[i]);
			end
		end
	end

	// output register with skid
	logic [151:0] out_q, skid_q, end_data;
	logic         out_valid_q, skid_valid_q, take;

	assign end_data = {2'b00, nvel_p4[2], nvel_p4[1], nvel_p4[0],
	                   npos_p4[2], npos_p4[1], npos_p4[0]};
	assign take     = out_valid_q && m_tready;
	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take)
				skid_valid_q <= 1'b0;
		end else if (v_p4) begin
			if (!out_valid_q || take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				out_q <= skid_q;
		end else if (v_p4) begin
			if (!out_valid_q || take)
				out_q <= end_data;
			else
				skid_q <= end_data;
		end
	end

endmodule

>>> hdl/bib_check.sv
// Port-level checks on the boid integrator handshakes.
module bib_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [255:0]                      s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [151:0]                      m_tdata,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [bib_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [bib_pkg::CFG_DAT_W-1:0]     cfg_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item dropped or changed while stalled");

	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no item waiting at output");

	a_skid_refill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !s_tready |=> m_tvalid)
		else $error("buffered item not moved to output");

	a_skid_keep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !s_tready |=> !s_tready)
		else $error("input released while buffer still full");

endmodule

bind boid_integrate_and_bound bib_check u_bib_check (.*);
